/* rtl/tkthq_pkg.sv */
`timescale 1ns / 1ps

package tkthq_pkg;

    localparam int KEY_SLOTS = 2;
    localparam int CFG_BITS  = 16;

    typedef logic [1:0] key_event_t;

    localparam key_event_t EV_NONE = 2'd0;
    localparam key_event_t EV_TAP  = 2'd1;
    localparam key_event_t EV_HOLD = 2'd2;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_NAV_THRESHOLD    = 2'd0;
    localparam reg_index_t REG_SELECT_THRESHOLD = 2'd1;
    localparam reg_index_t REG_DEBOUNCE_MS      = 2'd2;
    localparam reg_index_t REG_LONG_PRESS_MS    = 2'd3;

    localparam logic [CFG_BITS-1:0] THRESHOLD_RESET  = 16'd1;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd200;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd700;

endpackage

/* rtl/touch_key_tap_hold_qualifier.sv */
`timescale 1ns / 1ps

// A sample accepted on s_axis is captured in the input register, and its result is captured in
// the result register, which drives m_axis.
// Throughput: one sample per cycle; the per-key update is a single pass of
// compares and two subtractions, and a stalled result holds the sample in the input register.
// Reset (rst_n low, asynchronous): all key state cleared, both stages empty,
// thresholds 1, debounce 200 ms, long press 700 ms.
module touch_key_tap_hold_qualifier
    import tkthq_pkg::*;
#(
    parameter int KEY_COUNT = 2,
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] now_ms, [47:32] nav_raw, [63:48] select_raw

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [1:0] nav_event, [3:2] select_event,
                                       // [4] nav_pressed, [5] select_pressed, [7:6] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ACTIVE_KEYS = (KEY_COUNT < KEY_SLOTS) ? KEY_COUNT : KEY_SLOTS;

    logic [CFG_BITS-1:0] nav_threshold_reg;
    logic [CFG_BITS-1:0] select_threshold_reg;
    logic [CFG_BITS-1:0] debounce_ms_reg;
    logic [CFG_BITS-1:0] long_press_ms_reg;

    logic                in_valid_reg;
    logic [31:0]         in_now_reg;
    logic [15:0]         in_nav_reg;
    logic [15:0]         in_select_reg;

    logic                out_valid_reg;
    logic [5:0]          out_data_reg;

    logic                advance;
    logic                cfg_write;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] debounce_t;
    logic [TIME_BITS-1:0] long_press_t;

    logic [KEY_SLOTS-1:0][15:0]       reading;
    logic [KEY_SLOTS-1:0][CFG_BITS-1:0] threshold;
    key_event_t [KEY_SLOTS-1:0]       key_event;
    logic [KEY_SLOTS-1:0]             key_pressed;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nav_threshold_reg    <= THRESHOLD_RESET;
            select_threshold_reg <= THRESHOLD_RESET;
            debounce_ms_reg      <= DEBOUNCE_RESET;
            long_press_ms_reg    <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_NAV_THRESHOLD:    nav_threshold_reg    <= pwdata[CFG_BITS-1:0];
                REG_SELECT_THRESHOLD: select_threshold_reg <= pwdata[CFG_BITS-1:0];
                REG_DEBOUNCE_MS:      debounce_ms_reg      <= pwdata[CFG_BITS-1:0];
                REG_LONG_PRESS_MS:    long_press_ms_reg    <= pwdata[CFG_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_NAV_THRESHOLD:    prdata = {16'd0, nav_threshold_reg};
            REG_SELECT_THRESHOLD: prdata = {16'd0, select_threshold_reg};
            REG_DEBOUNCE_MS:      prdata = {16'd0, debounce_ms_reg};
            REG_LONG_PRESS_MS:    prdata = {16'd0, long_press_ms_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // input register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_now_reg    <= s_axis_tdata[31:0];
            in_nav_reg    <= s_axis_tdata[47:32];
            in_select_reg <= s_axis_tdata[63:48];
        end
    end

    // per-key qualification
    assign now_t        = TIME_BITS'(in_now_reg);
    assign debounce_t   = TIME_BITS'(debounce_ms_reg);
    assign long_press_t = TIME_BITS'(long_press_ms_reg);

    assign reading[0]   = in_nav_reg;
    assign reading[1]   = in_select_reg;
    assign threshold[0] = nav_threshold_reg;
    assign threshold[1] = select_threshold_reg;

    for (genvar k = 0; k < KEY_SLOTS; k++)
    begin : g_key
        if (k < ACTIVE_KEYS)
        begin : g_active
            logic                 raw_touched_reg;
            logic                 stable_touched_reg;
            logic                 hold_reported_reg;
            logic [TIME_BITS-1:0] change_time_reg;
            logic [TIME_BITS-1:0] press_start_time_reg;

            logic                 raw_touched_next;
            logic                 stable_touched_next;
            logic                 hold_reported_next;
            logic [TIME_BITS-1:0] change_time_next;
            logic [TIME_BITS-1:0] press_start_time_next;

            logic                 raw;
            logic [TIME_BITS-1:0] since_change;
            logic [TIME_BITS-1:0] since_press;
            key_event_t           ev;

            always_comb
            begin
                raw                   = reading[k] < threshold[k];
                raw_touched_next      = raw;
                change_time_next      = (raw != raw_touched_reg) ? now_t : change_time_reg;
                stable_touched_next   = stable_touched_reg;
                hold_reported_next    = hold_reported_reg;
                press_start_time_next = press_start_time_reg;
                since_change          = now_t - change_time_next;
                since_press           = now_t - press_start_time_reg;
                ev                    = EV_NONE;

                priority if (since_change < debounce_t)
                begin
                    ev = EV_NONE;
                end
                else if (raw != stable_touched_reg)
                begin
                    stable_touched_next = raw;
                    if (raw)
                    begin
                        press_start_time_next = now_t;
                        hold_reported_next    = 1'b0;
                    end
                    else if (!hold_reported_reg)
                    begin
                        ev = EV_TAP;
                    end
                end
                else if (stable_touched_reg && !hold_reported_reg &&
                         since_press >= long_press_t)
                begin
                    hold_reported_next = 1'b1;
                    ev                 = EV_HOLD;
                end
                else
                begin
                    ev = EV_NONE;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    raw_touched_reg      <= 1'b0;
                    stable_touched_reg   <= 1'b0;
                    hold_reported_reg    <= 1'b0;
                    change_time_reg      <= '0;
                    press_start_time_reg <= '0;
                end
                else if (advance)
                begin
                    raw_touched_reg      <= raw_touched_next;
                    stable_touched_reg   <= stable_touched_next;
                    hold_reported_reg    <= hold_reported_next;
                    change_time_reg      <= change_time_next;
                    press_start_time_reg <= press_start_time_next;
                end
            end

            assign key_event[k]   = ev;
            assign key_pressed[k] = stable_touched_next;
        end
        else
        begin : g_unused
            assign key_event[k]   = EV_NONE;
            assign key_pressed[k] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {key_pressed[1], key_pressed[0], key_event[1], key_event[0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

/* verif/touch_key_tap_hold_qualifier_test.sv */
`timescale 1ns / 1ps

module touch_key_tap_hold_qualifier_test;

    import tkthq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 120;

    typedef struct packed {
        logic [15:0] select_raw;
        logic [15:0] nav_raw;
        logic [31:0] now_ms;
    } touch_sample_t;

    typedef struct packed {
        logic [1:0] spare;
        logic       select_pressed;
        logic       nav_pressed;
        key_event_t select_event;
        key_event_t nav_event;
    } key_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    touch_key_tap_hold_qualifier u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the block's configuration and per-key state
    logic [15:0] thr_cfg [KEY_SLOTS];
    logic [15:0] debounce_cfg;
    logic [15:0] long_press_cfg;
    logic        raw_seen [KEY_SLOTS];
    logic        stable_on [KEY_SLOTS];
    logic        hold_done [KEY_SLOTS];
    logic [31:0] changed_at [KEY_SLOTS];
    logic [31:0] press_at [KEY_SLOTS];

    touch_sample_t pending_samples[$];
    key_report_t   expected_reports[$];

    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          samples_sent = 0;
    int          reports_checked = 0;
    int          taps_seen = 0;
    int          holds_seen = 0;
    int          cycle_count = 0;
    logic [31:0] cur_ms = '0;
    bit          key_on [KEY_SLOTS];
    int          run_left [KEY_SLOTS];

    function automatic key_event_t qualify_key(int k, logic [31:0] now, logic [15:0] reading);
        logic        raw;
        logic [31:0] since_change;
        logic [31:0] since_press;
        raw = reading < thr_cfg[k];
        if (raw != raw_seen[k])
        begin
            raw_seen[k]   = raw;
            changed_at[k] = now;
        end
        since_change = now - changed_at[k];
        if (since_change < {16'd0, debounce_cfg})
            return EV_NONE;
        if (raw != stable_on[k])
        begin
            stable_on[k] = raw;
            if (raw)
            begin
                press_at[k]  = now;
                hold_done[k] = 1'b0;
                return EV_NONE;
            end
            return hold_done[k] ? EV_NONE : EV_TAP;
        end
        since_press = now - press_at[k];
        if (stable_on[k] && !hold_done[k] && since_press >= {16'd0, long_press_cfg})
        begin
            hold_done[k] = 1'b1;
            return EV_HOLD;
        end
        return EV_NONE;
    endfunction

    function automatic key_report_t qualify_sample(touch_sample_t s);
        key_report_t r;
        r = '0;
        r.nav_event      = qualify_key(0, s.now_ms, s.nav_raw);
        r.nav_pressed    = stable_on[0];
        r.select_event   = qualify_key(1, s.now_ms, s.select_raw);
        r.select_pressed = stable_on[1];
        return r;
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_reports.push_back(qualify_sample(touch_sample_t'(s_axis_tdata)));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_samples.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic log_mismatch(string what, key_report_t want, key_report_t got);
        if (mismatches < 10)
            $display("%0t %s: expected nav %0d/%0b select %0d/%0b, got nav %0d/%0b select %0d/%0b",
                     $realtime, what, want.nav_event, want.nav_pressed, want.select_event,
                     want.select_pressed, got.nav_event, got.nav_pressed, got.select_event,
                     got.select_pressed);
        mismatches++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        key_report_t got;
        key_report_t want;
        got = key_report_t'(m_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (got.nav_event == EV_TAP || got.select_event == EV_TAP)
                taps_seen++;
            if (got.nav_event == EV_HOLD || got.select_event == EV_HOLD)
                holds_seen++;
            if (expected_reports.size() == 0)
                log_mismatch("unexpected result", '0, got);
            else
            begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (got.nav_event != want.nav_event || got.nav_pressed != want.nav_pressed ||
                    got.select_event != want.select_event ||
                    got.select_pressed != want.select_pressed)
                    log_mismatch("result mismatch", want, got);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("FAIL touch_key_tap_hold_qualifier");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NAV_THRESHOLD:    thr_cfg[0] = val;
            REG_SELECT_THRESHOLD: thr_cfg[1] = val;
            REG_DEBOUNCE_MS:      debounce_cfg = val;
            REG_LONG_PRESS_MS:    long_press_cfg = val;
            default: ;
        endcase
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {16'd0, val})
        begin
            if (mismatches < 10)
                $display("%0t readback of register %0d: expected %h, got %h",
                         $realtime, idx, val, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(logic [15:0] nav_thr, logic [15:0] sel_thr,
                                 logic [15:0] deb, logic [15:0] lp);
        write_reg(REG_NAV_THRESHOLD, nav_thr);
        write_reg(REG_SELECT_THRESHOLD, sel_thr);
        write_reg(REG_DEBOUNCE_MS, deb);
        write_reg(REG_LONG_PRESS_MS, lp);
    endtask

    task automatic add_sample(logic [31:0] t, logic [15:0] nav, logic [15:0] sel);
        touch_sample_t s;
        s.now_ms     = t;
        s.nav_raw    = nav;
        s.select_raw = sel;
        pending_samples.push_back(s);
    endtask

    function automatic logic [15:0] make_reading(bit on, logic [15:0] thr);
        if ($urandom_range(9) == 0)
            return (on && thr != 0) ? thr - 16'd1 : thr;
        if (on && thr != 0)
            return 16'($urandom_range(thr - 1, 0));
        return 16'($urandom_range(65535, thr));
    endfunction

    // mostly press/release runs with random content and lengths; some glitches and noise
    task automatic queue_random_samples(int count);
        logic [15:0] readings [KEY_SLOTS];
        int          span;
        bit          on;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            if ($urandom_range(99) < 8)
                add_sample($urandom, 16'($urandom), 16'($urandom));
            else
            begin
                span = debounce_cfg + long_press_cfg;
                cur_ms += $urandom_range(span / 3 + 2, 0);
                for (int k = 0; k < KEY_SLOTS; k++)
                begin
                    if (run_left[k] == 0)
                    begin
                        key_on[k]   = !key_on[k];
                        run_left[k] = $urandom_range(10, 1);
                    end
                    run_left[k]--;
                    on = key_on[k] ^ ($urandom_range(99) < 5);
                    readings[k] = make_reading(on, thr_cfg[k]);
                end
                add_sample(cur_ms, readings[0], readings[1]);
            end
        end
    endtask

    initial
    begin
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            thr_cfg[k]    = THRESHOLD_RESET;
            raw_seen[k]   = 1'b0;
            stable_on[k]  = 1'b0;
            hold_done[k]  = 1'b0;
            changed_at[k] = '0;
            press_at[k]   = '0;
            key_on[k]     = 1'b0;
            run_left[k]   = 0;
        end
        debounce_cfg   = DEBOUNCE_RESET;
        long_press_cfg = LONG_PRESS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: hold then release, threshold edge, glitch, taps, wrap, time going back
        add_sample(32'd0, 16'h0000, 16'hFFFF);
        add_sample(32'd150, 16'h0000, 16'hFFFF);
        add_sample(32'd200, 16'h0000, 16'h0000);
        add_sample(32'd899, 16'h0000, 16'h0000);
        add_sample(32'd900, 16'h0000, 16'h0000);
        add_sample(32'd1000, 16'h0001, 16'h0000);
        add_sample(32'd1300, 16'h0001, 16'h0000);
        add_sample(32'd1600, 16'hFFFF, 16'h0000);
        add_sample(32'd1650, 16'hFFFF, 16'hFFFF);
        add_sample(32'd1900, 16'hFFFF, 16'hFFFF);
        add_sample(32'd2000, 16'h0000, 16'hFFFF);
        add_sample(32'd2100, 16'hFFFF, 16'hFFFF);
        add_sample(32'd2400, 16'h0000, 16'h0000);
        add_sample(32'd2600, 16'h0000, 16'h0000);
        add_sample(32'd2700, 16'hFFFF, 16'hFFFF);
        add_sample(32'd2900, 16'hFFFF, 16'hFFFF);
        add_sample(32'hFFFF_FF80, 16'h0000, 16'h0000);
        add_sample(32'h0000_0050, 16'h0000, 16'h0000);
        add_sample(32'h0000_0020, 16'h0000, 16'h0000);
        add_sample(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        add_sample(32'h0000_00C7, 16'hFFFF, 16'hFFFF);
        wait_drained();

        apply_setting(16'h8000, 16'h8000, 16'd20, 16'd100);
        queue_random_samples(RANDOM_ITEMS);
        wait_drained();

        sender_idle_pct = 61;
        apply_setting(16'hFFFF, 16'h0001, 16'd0, 16'd0);
        queue_random_samples(RANDOM_ITEMS);
        wait_drained();

        sender_idle_pct = 0;
        recv_stall_pct  = 61;
        cur_ms = 32'hFFFF_0000;
        apply_setting(16'h0000, 16'h1234, 16'hFFFF, 16'hFFFF);
        queue_random_samples(RANDOM_ITEMS);
        wait_drained();

        sender_idle_pct = 30;
        recv_stall_pct  = 30;
        apply_setting(16'd3000, 16'd40000, 16'd50, 16'd0);
        queue_random_samples(RANDOM_ITEMS);
        wait_drained();

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        queue_random_samples(RANDOM_ITEMS);
        wait_drained();

        repeat (10) @(negedge clk);
        if (expected_reports.size() != 0)
            mismatches++;
        $display("%0d samples under six register settings, %0d results checked",
                 samples_sent, reports_checked);
        $display("%0d results with a tap, %0d with a hold, %0d mismatches",
                 taps_seen, holds_seen, mismatches);
        if (mismatches == 0)
            $display("PASS touch_key_tap_hold_qualifier");
        else
            $display("FAIL touch_key_tap_hold_qualifier");
        $finish;
    end

endmodule

/* sim.f */
rtl/tkthq_pkg.sv
rtl/touch_key_tap_hold_qualifier.sv
verif/touch_key_tap_hold_qualifier_test.sv
